### rtl/vep_pkg.sv
package vep_pkg;

   localparam int ECHO_DEPTH_DEF  = 12000;
   localparam int PITCH_DEPTH_DEF = 1920;
   localparam int ROBOT_HALF_DEF  = 45;

   localparam int SAMPLE_W = 16;
   localparam int INT_W    = 9;
   localparam int WEIGHT_W = 11;
   localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
   localparam int SCALED_W = PROD_W - 8;
   localparam int STEP_W   = 18;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [2:0] MODE_CLEAN = 3'd0;
   localparam logic [2:0] MODE_ECHO  = 3'd1;
   localparam logic [2:0] MODE_ROBOT = 3'd2;
   localparam logic [2:0] MODE_DEEP  = 3'd3;
   localparam logic [2:0] MODE_CHIP  = 3'd4;

   localparam logic [0:0] REG_MODE      = 1'b0;
   localparam logic [0:0] REG_INTENSITY = 1'b1;

   localparam logic [INT_W-1:0] INTENSITY_RESET = 9'd128;

   typedef struct packed {
      logic [2:0]        mode;
      logic [INT_W-1:0]  intensity;
      logic [STEP_W-1:0] slow_step;
      logic [STEP_W-1:0] chip_step;
   } cfg_type;

   typedef struct packed {
      logic go;
      logic deep;
   } pitch_cmd_type;

endpackage

### rtl/vep_csr.sv
module vep_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [vep_pkg::CSR_AW-1:0]   paddr,
   input  logic [vep_pkg::CSR_DW-1:0]   pwdata,
   output logic [vep_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output vep_pkg::cfg_type             cfg
);
   import vep_pkg::*;

   localparam logic [13:0]       DEEP_COEF = 14'd13107;
   localparam logic [15:0]       CHIP_COEF = 16'd45875;
   localparam logic [STEP_W-1:0] Q16_ONE   = 18'd65536;

   // Pitch steps are worked out when intensity is written, so the pointer
   // update needs only an add.
   function automatic logic [STEP_W-1:0] slow_step_of(input logic [INT_W-1:0] i);
      logic [INT_W+14-1:0] p;
      p = (INT_W+14)'(i) * (INT_W+14)'(DEEP_COEF);
      return Q16_ONE - STEP_W'(p >> 8);
   endfunction

   function automatic logic [STEP_W-1:0] chip_step(input logic [INT_W-1:0] i);
      logic [INT_W+16-1:0] p;
      p = (INT_W+16)'(i) * (INT_W+16)'(CHIP_COEF);
      return Q16_ONE + STEP_W'(p >> 8);
   endfunction

   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [0:0] reg_idx;

   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (reg_idx)
            REG_MODE: begin
               cfg_in.mode = pwdata[2:0];
            end
            REG_INTENSITY: begin
               cfg_in.intensity = pwdata[INT_W-1:0];
               cfg_in.slow_step = slow_step_of(pwdata[INT_W-1:0]);
               cfg_in.chip_step = chip_step(pwdata[INT_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:      prdata = CSR_DW'(cfg_ff.mode);
         REG_INTENSITY: prdata = CSR_DW'(cfg_ff.intensity);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_CLEAN;
         cfg_ff.intensity <= INTENSITY_RESET;
         cfg_ff.slow_step <= slow_step_of(INTENSITY_RESET);
         cfg_ff.chip_step <= chip_step(INTENSITY_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/vep_echo.sv
module vep_echo #(
   parameter int ECHO_DEPTH = vep_pkg::ECHO_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                commit,
   input  logic                                mix_back,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] held_sample,
   output logic signed [vep_pkg::SAMPLE_W-1:0] delayed
);
   import vep_pkg::*;

   localparam int IDX_W = $clog2(ECHO_DEPTH);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ECHO_DEPTH - 1);

   function automatic logic signed [SAMPLE_W-1:0] div2_trunc(
      input logic signed [SAMPLE_W-1:0] x);
      logic signed [SAMPLE_W:0] t;
      t = (SAMPLE_W+1)'(x) + (SAMPLE_W+1)'(x[SAMPLE_W-1]);
      return SAMPLE_W'(t >>> 1);
   endfunction

   // Divide by three through the reciprocal 43691 / 2^17, exact for 16-bit magnitudes.
   function automatic logic signed [SAMPLE_W-1:0] div3_trunc(
      input logic signed [SAMPLE_W-1:0] x);
      logic signed [SAMPLE_W:0] xs;
      logic [SAMPLE_W:0]        mag;
      logic [2*SAMPLE_W+1:0]    prod;
      logic signed [SAMPLE_W-1:0] q;
      xs   = (SAMPLE_W+1)'(x);
      mag  = x[SAMPLE_W-1] ? -xs : xs;
      prod = (2*SAMPLE_W+2)'(mag) * (2*SAMPLE_W+2)'(17'd43691);
      q    = SAMPLE_W'(prod >> 17);
      return x[SAMPLE_W-1] ? -q : q;
   endfunction

   logic signed [SAMPLE_W-1:0] mem [ECHO_DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [IDX_W-1:0]           wr_addr_ff;
   logic                       wrapped_ff, wrapped_in;
   logic                       ok_ff;
   logic signed [SAMPLE_W-1:0] wdata;

   // Entries ahead of the write position are unwritten until the first lap ends.
   assign delayed = ok_ff ? rdata_ff : '0;
   assign wdata   = mix_back ? div2_trunc(held_sample) + div3_trunc(delayed) : held_sample;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (pos_ff == LAST) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff   <= mem[pos_ff];
         wr_addr_ff <= pos_ff;
         ok_ff      <= wrapped_ff;
      end
      if (commit) begin
         mem[wr_addr_ff] <= wdata;
      end
   end

endmodule

### rtl/vep_pitch.sv
module vep_pitch #(
   parameter int PITCH_DEPTH = vep_pkg::PITCH_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  vep_pkg::pitch_cmd_type              cmd,
   input  vep_pkg::cfg_type                    cfg,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] held_sample,
   output logic signed [vep_pkg::SAMPLE_W-1:0] shifted
);
   import vep_pkg::*;

   localparam int IDX_W = $clog2(PITCH_DEPTH);
   localparam int POS_W = IDX_W + 16;
   localparam int SUM_W = POS_W + 2;
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(PITCH_DEPTH - 1);
   localparam logic [SUM_W-1:0] SPAN1 = SUM_W'(PITCH_DEPTH) << 16;
   localparam logic [SUM_W-1:0] SPAN2 = SPAN1 << 1;

   logic signed [SAMPLE_W-1:0] mem [PITCH_DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic [IDX_W-1:0]           wp_ff, wp_in;
   logic                       wrapped_ff, wrapped_in;
   logic [POS_W-1:0]           deep_ff, deep_in;
   logic [POS_W-1:0]           chip_ff, chip_in;
   logic                       hit_ff, ok_ff;
   logic [POS_W-1:0]           cur_pos, nxt_pos;
   logic [STEP_W-1:0]          step;
   logic [SUM_W-1:0]           sum;
   logic [IDX_W-1:0]           rd_idx;

   assign cur_pos = cmd.deep ? deep_ff : chip_ff;
   assign step    = cmd.deep ? cfg.slow_step : cfg.chip_step;
   assign sum     = SUM_W'(cur_pos) + SUM_W'(step);
   assign rd_idx  = nxt_pos[POS_W-1:16];

   // A large step on a short store can overrun the span twice.
   always_comb begin
      if (sum >= SPAN2) begin
         nxt_pos = POS_W'(sum - SPAN2);
      end else if (sum >= SPAN1) begin
         nxt_pos = POS_W'(sum - SPAN1);
      end else begin
         nxt_pos = POS_W'(sum);
      end
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      deep_in    = deep_ff;
      chip_in    = chip_ff;
      if (accept) begin
         if (wp_ff == LAST) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
         if (cmd.go && cmd.deep) begin
            deep_in = nxt_pos;
         end
         if (cmd.go && !cmd.deep) begin
            chip_in = nxt_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         deep_ff    <= '0;
         chip_ff    <= '0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         deep_ff    <= deep_in;
         chip_ff    <= chip_in;
      end
   end

   // The read may land on the entry written by the same beat; that case is
   // forwarded from the held sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem[wp_ff] <= sample;
         rdata_ff   <= mem[rd_idx];
         hit_ff     <= (rd_idx == wp_ff);
         ok_ff      <= wrapped_ff || (rd_idx < wp_ff);
      end
   end

   always_comb begin
      if (hit_ff) begin
         shifted = held_sample;
      end else if (ok_ff) begin
         shifted = rdata_ff;
      end else begin
         shifted = '0;
      end
   end

endmodule

### rtl/vep_mix.sv
module vep_mix (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] other,
   input  logic signed [vep_pkg::WEIGHT_W-1:0] weight_a,
   input  logic signed [vep_pkg::WEIGHT_W-1:0] weight_b,
   output logic signed [vep_pkg::SAMPLE_W-1:0] result
);
   import vep_pkg::*;

   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   // Q8 scaling with truncation toward zero.
   function automatic logic signed [SCALED_W-1:0] trunc_q8(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      return SCALED_W'(t >>> 8);
   endfunction

   logic signed [PROD_W-1:0]   prod_a_ff, prod_b_ff;
   logic signed [SCALED_W:0]   sum;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_a_ff <= PROD_W'(sample) * PROD_W'(weight_a);
         prod_b_ff <= PROD_W'(other) * PROD_W'(weight_b);
      end
   end

   assign sum = (SCALED_W+1)'(trunc_q8(prod_a_ff)) + (SCALED_W+1)'(trunc_q8(prod_b_ff));

   always_comb begin
      if (sum > SAT_MAX) begin
         result = SAMPLE_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         result = SAMPLE_W'(SAT_MIN);
      end else begin
         result = SAMPLE_W'(sum);
      end
   end

endmodule

### rtl/voice_effect_processor.sv
// Voice effect processor: one signed 16-bit sample in, one processed sample out.
//
// Samples enter on the req_ channel and leave on the rsp_ channel, both with
// valid/ready; a beat moves when valid and ready are high at a clock edge.
// Results leave in the order the samples came in, one for each sample.
// The csr_ port is an APB-style slave with two registers: effect mode at
// byte address 0 and intensity at byte address 4. Write them only while
// no sample is in flight.
//
// The pipe takes one sample per cycle while the receiver keeps up: the
// accept reads the echo and pitch memories, the move out of the first stage
// registers the two weight products and writes the echo mix back, and the
// output register holds the saturated sum.
// When the receiver stalls, up to two more samples are taken before
// req_ready drops; nothing is lost or repeated.
//
// Reset is synchronous. It clears the pipe, the positions, the pitch
// pointers and the robot phase. Unwritten store entries read as zero through
// per-store fill tracking, so no clearing pass is needed.
module voice_effect_processor #(
   parameter int ECHO_DEPTH        = vep_pkg::ECHO_DEPTH_DEF,
   parameter int PITCH_DEPTH       = vep_pkg::PITCH_DEPTH_DEF,
   parameter int ROBOT_HALF_PERIOD = vep_pkg::ROBOT_HALF_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [vep_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vep_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vep_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [vep_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [vep_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import vep_pkg::*;

   localparam int PHASE_W = $clog2(2 * ROBOT_HALF_PERIOD);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * ROBOT_HALF_PERIOD - 1);
   localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(ROBOT_HALF_PERIOD);
   localparam logic signed [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(256);
   localparam logic [INT_W-1:0] PITCH_MIN_INT = 9'd2;

   cfg_type       cfg;
   pitch_cmd_type pcmd;

   logic accept;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_free, s1_free, s1_move, s2_move;

   logic signed [SAMPLE_W-1:0] x_s1_ff;
   logic signed [WEIGHT_W-1:0] wa_ff, wa_in, wb_ff, wb_in;
   logic                       use_echo_ff, use_echo_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in, phase_step;
   logic signed [WEIGHT_W-1:0] i_w;

   logic signed [SAMPLE_W-1:0] echo_d, pitch_d, mix_d, mix_out;
   logic signed [SAMPLE_W-1:0] out_ff;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && out_free;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_ff;

   assign i_w        = signed'(WEIGHT_W'(cfg.intensity));
   assign phase_step = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;

   assign pcmd.go   = ((cfg.mode == MODE_DEEP) || (cfg.mode == MODE_CHIP)) &&
                      (cfg.intensity > PITCH_MIN_INT);
   assign pcmd.deep = (cfg.mode == MODE_DEEP);

   // Every mode is cast as trunc(x*wa/256) + trunc(d*wb/256).
   always_comb begin
      wa_in       = W_ONE;
      wb_in       = '0;
      use_echo_in = 1'b0;
      phase_in    = phase_ff;
      case (cfg.mode) inside
         MODE_ECHO: begin
            wa_in       = W_ONE - i_w;
            wb_in       = i_w;
            use_echo_in = 1'b1;
         end
         MODE_ROBOT: begin
            if (accept) begin
               phase_in = phase_step;
            end
            if (phase_step >= PHASE_HALF) begin
               wa_in = W_ONE - (i_w <<< 1);
            end
         end
         MODE_DEEP, MODE_CHIP: begin
            if (pcmd.go) begin
               wa_in = '0;
               wb_in = W_ONE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s2_valid_in  = s1_move || (s2_valid_ff && !s2_move);
      out_valid_in = s2_move || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_s1_ff     <= req_sample_in;
         wa_ff       <= wa_in;
         wb_ff       <= wb_in;
         use_echo_ff <= use_echo_in;
      end
      if (s2_move) begin
         out_ff <= mix_out;
      end
   end

   assign mix_d = use_echo_ff ? echo_d : pitch_d;

   vep_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   vep_echo #(
      .ECHO_DEPTH (ECHO_DEPTH)
   ) u_echo (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .commit      (s1_move),
      .mix_back    (use_echo_ff),
      .held_sample (x_s1_ff),
      .delayed     (echo_d)
   );

   vep_pitch #(
      .PITCH_DEPTH (PITCH_DEPTH)
   ) u_pitch (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (pcmd),
      .cfg         (cfg),
      .sample      (req_sample_in),
      .held_sample (x_s1_ff),
      .shifted     (pitch_d)
   );

   vep_mix u_mix (
      .clock    (clock),
      .load     (s1_move),
      .sample   (x_s1_ff),
      .other    (mix_d),
      .weight_a (wa_ff),
      .weight_b (wb_ff),
      .result   (mix_out)
   );

endmodule

### rtl/vep_checker.sv
module vep_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [vep_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   // A waiting result beat holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input side only backs off when the output register is stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input not ready without an output stall");

   // With the receiver ready, an accepted sample reaches the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind voice_effect_processor vep_checker u_vep_checker (.*);

### dv/tb_voice_effect_processor.sv
`timescale 1ns / 1ps

class effect_scoreboard;
   localparam int     ECHO_SLOTS   = vep_pkg::ECHO_DEPTH_DEF;
   localparam int     PITCH_SLOTS  = vep_pkg::PITCH_DEPTH_DEF;
   localparam int     ROBOT_HALF   = vep_pkg::ROBOT_HALF_DEF;
   localparam longint PITCH_SPAN   = longint'(vep_pkg::PITCH_DEPTH_DEF) * 65536;
   localparam longint UNITY_Q16    = 65536;
   localparam longint DEEP_RATE    = 13107;
   localparam longint CHIP_RATE    = 45875;
   localparam longint BYPASS_LIMIT = 2;
   localparam longint SAT_HIGH     = 32767;
   localparam longint SAT_LOW      = -32768;

   logic [2:0]             mode;
   logic [8:0]             strength;
   logic signed [15:0]     echo_mem [ECHO_SLOTS];
   logic signed [15:0]     pitch_mem [PITCH_SLOTS];
   int                     echo_wr;
   int                     pitch_wr;
   longint                 deep_ptr;
   longint                 chip_ptr;
   int                     robot_cnt;
   logic signed [15:0]     pending_outputs [$];
   int                     errors;

   function void reset_state();
      foreach (echo_mem[i]) echo_mem[i] = '0;
      foreach (pitch_mem[i]) pitch_mem[i] = '0;
      echo_wr   = 0;
      pitch_wr  = 0;
      deep_ptr  = 0;
      chip_ptr  = 0;
      robot_cnt = 0;
      mode      = vep_pkg::MODE_CLEAN;
      strength  = vep_pkg::INTENSITY_RESET;
      pending_outputs.delete();
      errors    = 0;
   endfunction

   function void write_register(logic [0:0] index, logic [31:0] value);
      if (index == vep_pkg::REG_MODE) begin
         mode = value[2:0];
      end else begin
         strength = value[8:0];
      end
   endfunction

   function int pending();
      return pending_outputs.size();
   endfunction

   // Works out the output for one accepted sample and advances all store state.
   function void note_sample(logic signed [15:0] sample);
      longint             x;
      longint             d;
      longint             wt;
      longint             res;
      logic signed [15:0] writeback;
      x = sample;
      wt = strength;
      res = x;
      writeback = sample;
      pitch_mem[pitch_wr] = sample;
      case (mode)
         vep_pkg::MODE_ECHO: begin
            d = echo_mem[echo_wr];
            res = (x * (256 - wt)) / 256 + (d * wt) / 256;
            writeback = 16'(x / 2 + d / 3);
         end
         vep_pkg::MODE_ROBOT: begin
            robot_cnt = (robot_cnt + 1) % (2 * ROBOT_HALF);
            if (robot_cnt >= ROBOT_HALF) begin
               res = (x * (256 - 2 * wt)) / 256;
            end
         end
         vep_pkg::MODE_DEEP: begin
            if (wt > BYPASS_LIMIT) begin
               deep_ptr = (deep_ptr + UNITY_Q16 - (wt * DEEP_RATE) / 256) % PITCH_SPAN;
               res = pitch_mem[deep_ptr >> 16];
            end
         end
         vep_pkg::MODE_CHIP: begin
            if (wt > BYPASS_LIMIT) begin
               chip_ptr = (chip_ptr + UNITY_Q16 + (wt * CHIP_RATE) / 256) % PITCH_SPAN;
               res = pitch_mem[chip_ptr >> 16];
            end
         end
         default: begin
         end
      endcase
      echo_mem[echo_wr] = writeback;
      echo_wr = (echo_wr + 1) % ECHO_SLOTS;
      pitch_wr = (pitch_wr + 1) % PITCH_SLOTS;
      if (res > SAT_HIGH) begin
         res = SAT_HIGH;
      end else if (res < SAT_LOW) begin
         res = SAT_LOW;
      end
      pending_outputs.push_back(16'(res));
   endfunction

   function void check_sample(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (pending_outputs.size() == 0) begin
         if (errors < 50) begin
            $error("sample_out: beat with nothing pending, actual %0d", actual);
         end
         errors++;
         return;
      end
      want = pending_outputs.pop_front();
      if (actual !== want) begin
         if (errors < 50) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, actual);
         end
         errors++;
      end
   endfunction
endclass

module tb_voice_effect_processor;
   import vep_pkg::*;

   localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] MODE_LAST         = 3'd7;
   localparam int         MAX_STRENGTH      = 511;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_psel      = 1'b0;
   logic                       csr_penable   = 1'b0;
   logic                       csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr     = '0;
   logic [CSR_DW-1:0]          csr_pwdata    = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   effect_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent_count    = 0;
   int setting_count = 0;

   voice_effect_processor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_sample(rsp_sample_out);
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_mode();
      if ($urandom_range(9) < 8) begin
         return 3'($urandom_range(MODE_CHIP));
      end
      return 3'($urandom_range(MODE_LAST, MODE_UNUSED_FIRST));
   endfunction

   function automatic logic [8:0] pick_strength();
      int corners [6] = '{0, 1, 2, 3, 256, MAX_STRENGTH};
      case ($urandom_range(9))
         0: return 9'(corners[$urandom_range(5)]);
         1: return 9'($urandom_range(MAX_STRENGTH, 257));
         default: return 9'($urandom_range(256));
      endcase
   endfunction

   task automatic send_sample(logic signed [15:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(value);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Back-to-back transfers keep psel high; the caller drops it afterwards.
   task automatic csr_write(logic [0:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(index, value);
   endtask

   task automatic apply_setting(logic [2:0] mode, logic [8:0] strength);
      drain();
      csr_write(REG_MODE, 32'(mode));
      csr_write(REG_INTENSITY, 32'(strength));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   initial begin
      logic [2:0]         dir_mode [8] = '{MODE_CLEAN, MODE_ECHO, MODE_ECHO, MODE_ROBOT,
                                           MODE_DEEP, MODE_DEEP, MODE_CHIP,
                                           MODE_UNUSED_FIRST};
      int                 dir_strength [8] = '{128, 256, 0, MAX_STRENGTH, 2, 3,
                                               MAX_STRENGTH, 300};
      logic signed [15:0] corner_vals [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
      sb = new();
      sb.reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 58;
      for (int k = 0; k < 8; k++) begin
         apply_setting(dir_mode[k], 9'(dir_strength[k]));
         for (int i = 0; i < 3; i++) send_sample(corner_vals[(k + i) % 4]);
      end

      for (int p = 0; p < 24; p++) begin
         if (p == 8) begin
            send_idle_pct = 58;
            recv_idle_pct = 29;
         end else if (p == 16) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_setting(pick_mode(), pick_strength());
         repeat ($urandom_range(70, 30)) send_sample(pick_sample());
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d samples across %0d register settings under three idling patterns.",
               sent_count, setting_count);
      $display("Covered all mode codes, intensity up to 511 and full-scale sample corners.");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
